// ----- rtl/mp2d_pkg.sv -----
`timescale 1ns / 1ps
package mp2d_pkg;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_KERNEL = 8;

  localparam logic [31:0] NEG_INF_BITS = 32'hFF800000;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_POOL  = 1'b1;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH  = 3'd1;
  localparam logic [2:0] REG_KERNEL_H  = 3'd2;
  localparam logic [2:0] REG_KERNEL_W  = 3'd3;
  localparam logic [2:0] REG_STRIDE_H  = 3'd4;
  localparam logic [2:0] REG_STRIDE_W  = 3'd5;
  localparam logic [2:0] REG_PAD_TOP   = 3'd6;
  localparam logic [2:0] REG_PAD_LEFT  = 3'd7;

  typedef struct packed {
    logic [6:0] in_height;
    logic [6:0] in_width;
    logic [3:0] kernel_h;
    logic [3:0] kernel_w;
    logic [3:0] stride_h;
    logic [3:0] stride_w;
    logic [2:0] pad_top;
    logic [2:0] pad_left;
  } cfg_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F800000;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] x);
    return x[31] ? ~x : (x | 32'h80000000);
  endfunction

  function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] | b[30:0]) == 31'd0) return 1'b0;
    return order_key(a) > order_key(b);
  endfunction
endpackage

// ----- rtl/mp2d_cfg.sv -----
`timescale 1ns / 1ps
module mp2d_cfg
  import mp2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [2:0]  idx_i,
  input  logic [31:0] data_i,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{7'd64, 7'd64, 4'd2, 4'd2, 4'd2, 4'd2, 3'd0, 3'd0};
    end else if (we_i) begin
      unique case (idx_i)
        REG_IN_HEIGHT: cfg_q.in_height <= data_i[6:0];
        REG_IN_WIDTH:  cfg_q.in_width  <= data_i[6:0];
        REG_KERNEL_H:  cfg_q.kernel_h  <= data_i[3:0];
        REG_KERNEL_W:  cfg_q.kernel_w  <= data_i[3:0];
        REG_STRIDE_H:  cfg_q.stride_h  <= data_i[3:0];
        REG_STRIDE_W:  cfg_q.stride_w  <= data_i[3:0];
        REG_PAD_TOP:   cfg_q.pad_top   <= data_i[2:0];
        REG_PAD_LEFT:  cfg_q.pad_left  <= data_i[2:0];
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule

// ----- rtl/max_pool_2d_window.sv -----
`timescale 1ns / 1ps
// Pixel write: a new word can be taken every cycle while the block is idle.
// Pool request: one plane read per tap in the scan state (the scan ends at its first step if a
// kernel size is zero), then the output state registers the maximum. No new word is taken
// until the result has been registered on the output; a result still held by the sink stalls
// the next request in the output state.
// Reset is asynchronous, active low; the plane store is not cleared.
module max_pool_2d_window
  import mp2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row[5:0], col[11:6], pixel_bits[43:12], zero fill
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // pooled_bits
  output logic        m_axis_tuser   // window_empty
);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW = RW + CW;
  localparam int KW = $clog2(MAX_KERNEL + 1);
  localparam int SW = 14;  // signed coordinate width

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_SCAN = 3'b010, S_OUT = 3'b100
  } state_e;

  cfg_t cfg;
  mp2d_cfg u_cfg (
    .clk_i, .rst_ni, .we_i(cfg_valid_i), .idx_i(cfg_index_i),
    .data_i(cfg_data_i), .cfg_o(cfg)
  );
  assign cfg_ready_o = 1'b1;

  logic [31:0] mem [2**AW];
  logic [31:0] rd_q;

  logic [5:0]  in_row, in_col;
  logic [31:0] in_pix;
  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];
  assign in_pix = s_axis_tdata[43:12];

  logic [10:0] h_eff, w_eff;
  logic [4:0]  kh_eff, kw_eff;
  always_comb begin
    h_eff  = ({4'd0, cfg.in_height} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT)
             : {4'd0, cfg.in_height};
    w_eff  = ({4'd0, cfg.in_width} > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH)
             : {4'd0, cfg.in_width};
    kh_eff = ({1'b0, cfg.kernel_h} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : {1'b0, cfg.kernel_h};
    kw_eff = ({1'b0, cfg.kernel_w} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : {1'b0, cfg.kernel_w};
  end

  state_e state_q, state_d;
  logic signed [SW-1:0] base_r_q, base_c_q;
  logic [KW-1:0] i_q, j_q;
  logic          rv_q;
  logic [31:0]   best_q;
  logic          empty_q;

  logic acc;
  logic out_free;
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  logic signed [SW-1:0] r, c;
  logic tap_in, last_tap;
  always_comb begin
    r = base_r_q + SW'(i_q);
    c = base_c_q + SW'(j_q);
    tap_in = (r >= 0) && (r < $signed({3'd0, h_eff})) && (c >= 0)
             && (c < $signed({3'd0, w_eff})) && (5'(i_q) < kh_eff) && (5'(j_q) < kw_eff);
    last_tap = (5'(i_q) + 5'd1 >= kh_eff) && (5'(j_q) + 5'd1 >= kw_eff);
  end

  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tuser == OP_WRITE && {5'd0, in_row} < h_eff && {5'd0, in_col} < w_eff)
      mem[{in_row[RW-1:0], in_col[CW-1:0]}] <= in_pix;
    rd_q <= mem[{r[RW-1:0], c[CW-1:0]}];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc && s_axis_tuser == OP_POOL) state_d = S_SCAN;
      S_SCAN: if (last_tap || kh_eff == 5'd0 || kw_eff == 5'd0) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      rv_q <= (state_q == S_SCAN) && tap_in;
    end
  end

  logic [31:0] best_n;
  always_comb begin
    best_n = (rv_q && fgt(rd_q, best_q)) ? rd_q : best_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && acc) begin
      base_r_q <= $signed({4'd0, in_row} * {6'd0, cfg.stride_h}) - SW'(cfg.pad_top);
      base_c_q <= $signed({4'd0, in_col} * {6'd0, cfg.stride_w}) - SW'(cfg.pad_left);
      i_q <= '0;
      j_q <= '0;
      best_q <= NEG_INF_BITS;
      empty_q <= 1'b1;
    end else if (state_q == S_SCAN) begin
      best_q <= best_n;
      if (tap_in) empty_q <= 1'b0;
      if (5'(j_q) + 5'd1 >= kw_eff) begin
        j_q <= '0;
        i_q <= i_q + KW'(1);
      end else begin
        j_q <= j_q + KW'(1);
      end
    end else if (state_q == S_OUT) begin
      best_q <= best_n;
      if (out_free) begin
        m_axis_tdata <= best_n;
        m_axis_tuser <= empty_q;
      end
    end
  end
endmodule
